>>> rtl/core/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types and constants of the range scan cluster segmenter.
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int MAX_POINTS_DEF = 1024;

  // Result field widths
  localparam int START_W = 10;
  localparam int COUNT_W = 11;

  // Configuration
  localparam int RANGE_W = 16;
  localparam int MINP_W  = 11;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;
  localparam int RIDX_W  = 2;

  localparam logic [RIDX_W-1:0] REG_JUMP_THRESHOLD  = 2'd0;
  localparam logic [RIDX_W-1:0] REG_MIN_VALID_RANGE = 2'd1;
  localparam logic [RIDX_W-1:0] REG_WRAP_MIN_RANGE  = 2'd2;
  localparam logic [RIDX_W-1:0] REG_MIN_POINTS      = 2'd3;

  localparam logic [RANGE_W-1:0] JUMP_THRESHOLD_RST  = 16'd50;
  localparam logic [RANGE_W-1:0] MIN_VALID_RANGE_RST = 16'd50;
  localparam logic [RANGE_W-1:0] WRAP_MIN_RANGE_RST  = 16'd100;
  localparam logic [MINP_W-1:0]  MIN_POINTS_RST      = 11'd4;

  // Result queue: one item yields at most three records
  localparam int SLOTS   = 3;
  localparam int Q_DEPTH = 8;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [RANGE_W-1:0] jump_threshold;
    logic [RANGE_W-1:0] min_valid_range;
    logic [RANGE_W-1:0] wrap_min_range;
    logic [MINP_W-1:0]  min_points;
  } cfg_t;

  typedef struct packed {
    logic [START_W-1:0] start_index;
    logic [COUNT_W-1:0] point_count;
    logic               is_cluster;
    logic               wrapped;
    logic               last_of_scan;
  } res_t;

endpackage

>>> rtl/core/range_scan_cluster_segmenter.sv
// ----------------------------------------------------------------------------
// range_scan_cluster_segmenter
// Breakpoint segmentation of a lidar range scan into clusters, with a
// wraparound merge of the first and last clusters at end of scan.
//
//   channel  direction  signals                                 handshake
//   input    in         range_mm, end_of_scan                   in_valid/in_ready
//   result   out        start_index, point_count, is_cluster,   out_valid/out_ready
//                       wrapped, last_of_scan
//   config   in/out     psel, penable, pwrite, paddr, pwdata,   APB, pready tied high
//                       prdata
//
// One sample per cycle while the queue has room: a sample waits in the input register,
// where the segmentation logic updates the scan state; its records enter the result
// queue as the sample leaves the register, and the queue head drives the result ports.
// A sample may add up to three records; the input register stalls while the
// eight-entry queue has fewer than three free entries.
// Reset clears the scan state, the queue and loads register defaults.
// ----------------------------------------------------------------------------
module range_scan_cluster_segmenter import rsc_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [RANGE_W-1:0] range_mm,
  input  logic               end_of_scan,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [START_W-1:0] start_index,
  output logic [COUNT_W-1:0] point_count,
  output logic               is_cluster,
  output logic               wrapped,
  output logic               last_of_scan,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  cfg_t               cfg;
  logic               q_valid;
  logic [RANGE_W-1:0] q_range;
  logic               q_eos;
  logic               room;
  logic               fire;
  res_t [SLOTS-1:0]   slot;
  logic [SLOTS-1:0]   slot_valid;
  res_t               head;

  assign fire     = q_valid && room;
  assign in_ready = !q_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      q_valid <= 1'b1;
    end else if (fire) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_range <= range_mm;
      q_eos   <= end_of_scan;
    end
  end

  rsc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rsc_step #(
    .MAX_POINTS (MAX_POINTS)
  ) u_step (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .range_in   (q_range),
    .eos_in     (q_eos),
    .cfg        (cfg),
    .slot       (slot),
    .slot_valid (slot_valid)
  );

  rsc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (fire),
    .slot       (slot),
    .slot_valid (slot_valid),
    .room       (room),
    .head_valid (out_valid),
    .head_taken (out_ready),
    .head       (head)
  );

  assign start_index  = head.start_index;
  assign point_count  = head.point_count;
  assign is_cluster   = head.is_cluster;
  assign wrapped      = head.wrapped;
  assign last_of_scan = head.last_of_scan;

endmodule

>>> rtl/core/rsc_regs.sv
// ----------------------------------------------------------------------------
// rsc_regs
// APB-style configuration registers: thresholds and minimum cluster size.
// ----------------------------------------------------------------------------
module rsc_regs import rsc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [RIDX_W-1:0] reg_idx;
  logic              wr_en;

  assign reg_idx = paddr[ADDR_W-1:ADDR_W-RIDX_W];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.jump_threshold  <= JUMP_THRESHOLD_RST;
      cfg.min_valid_range <= MIN_VALID_RANGE_RST;
      cfg.wrap_min_range  <= WRAP_MIN_RANGE_RST;
      cfg.min_points      <= MIN_POINTS_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_JUMP_THRESHOLD:  cfg.jump_threshold  <= pwdata[RANGE_W-1:0];
        REG_MIN_VALID_RANGE: cfg.min_valid_range <= pwdata[RANGE_W-1:0];
        REG_WRAP_MIN_RANGE:  cfg.wrap_min_range  <= pwdata[RANGE_W-1:0];
        REG_MIN_POINTS:      cfg.min_points      <= pwdata[MINP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_JUMP_THRESHOLD:  prdata = DATA_W'(cfg.jump_threshold);
      REG_MIN_VALID_RANGE: prdata = DATA_W'(cfg.min_valid_range);
      REG_WRAP_MIN_RANGE:  prdata = DATA_W'(cfg.wrap_min_range);
      REG_MIN_POINTS:      prdata = DATA_W'(cfg.min_points);
      default:             prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/rsc_step.sv
// ----------------------------------------------------------------------------
// rsc_step
// Scan state and per-sample segmentation: gap test, open/held cluster
// bookkeeping, wraparound merge, and up to three result records per sample.
// ----------------------------------------------------------------------------
module rsc_step import rsc_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     fire,
  input  logic [RANGE_W-1:0]       range_in,
  input  logic                     eos_in,
  input  cfg_t                     cfg,
  output res_t [SLOTS-1:0]         slot,
  output logic [SLOTS-1:0]         slot_valid
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int CMP_W = (SUM_W > MINP_W) ? SUM_W : MINP_W;
  localparam logic [SUM_W-1:0] MAX_SUM = SUM_W'(MAX_POINTS);
  localparam logic [IDX_W:0]   IDX_LIM = (IDX_W + 1)'(MAX_POINTS);
  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(MAX_POINTS - 1);

  logic [IDX_W-1:0]   sample_index, sample_index_next;
  logic [RANGE_W-1:0] previous_range, previous_range_next;
  logic [RANGE_W-1:0] first_range, first_range_next;
  logic [IDX_W-1:0]   open_start, open_start_next;
  logic [CNT_W-1:0]   open_count, open_count_next;
  logic [CNT_W-1:0]   held_count, held_count_next;
  logic               held_valid, held_valid_next;

  function automatic logic [RANGE_W-1:0] absdiff(input logic [RANGE_W-1:0] a,
                                                 input logic [RANGE_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [CNT_W-1:0] sat_sum(input logic [SUM_W-1:0] s);
    return (s > MAX_SUM) ? CNT_W'(MAX_POINTS) : s[CNT_W-1:0];
  endfunction

  function automatic logic big_enough(input logic [CNT_W-1:0] c,
                                      input logic [MINP_W-1:0] mp);
    return (c != '0) && (CMP_W'(c) >= CMP_W'(mp));
  endfunction

  logic               scan_start;
  logic [RANGE_W-1:0] first_eff;
  logic [CNT_W-1:0]   oc0, hc0, oc1, hc1;
  logic [IDX_W-1:0]   os1;
  logic               hv0, hv1;
  logic               valid, join_open, merge;
  logic [CNT_W-1:0]   merged;
  logic [IDX_W:0]     idx_inc;
  logic               va, vb, vc;

  always_comb begin
    scan_start = (sample_index == '0);
    first_eff  = scan_start ? range_in : first_range;
    oc0        = scan_start ? '0 : open_count;
    hc0        = scan_start ? '0 : held_count;
    hv0        = scan_start ? 1'b0 : held_valid;

    valid     = range_in > cfg.min_valid_range;
    join_open = valid && (oc0 != '0) &&
                (absdiff(range_in, previous_range) < cfg.jump_threshold);

    oc1 = oc0;
    os1 = open_start;
    hc1 = hc0;
    hv1 = hv0;
    va  = 1'b0;
    slot[0] = '0;
    slot[0].start_index = START_W'(open_start);
    slot[0].point_count = COUNT_W'(oc0);
    slot[0].is_cluster  = 1'b1;

    if (join_open) begin
      oc1 = sat_sum(SUM_W'(oc0) + SUM_W'(1));
    end else begin
      if (oc0 != '0) begin
        // cluster starting at sample 0 waits for a possible wrap merge
        if (open_start == '0) begin
          hv1 = 1'b1;
          hc1 = oc0;
        end else begin
          va = big_enough(oc0, cfg.min_points);
        end
      end
      oc1 = valid ? CNT_W'(1) : '0;
      os1 = valid ? sample_index : open_start;
    end

    merged = sat_sum(SUM_W'(oc1) + SUM_W'(hc1));
    merge  = eos_in && hv1 && (oc1 != '0) &&
             (absdiff(range_in, first_eff) < cfg.jump_threshold) &&
             (range_in > cfg.wrap_min_range);

    slot[1] = '0;
    slot[2] = '0;
    vb = 1'b0;
    vc = 1'b0;
    if (merge) begin
      vb = big_enough(merged, cfg.min_points);
      slot[1].start_index = START_W'(os1);
      slot[1].point_count = COUNT_W'(merged);
      slot[1].is_cluster  = 1'b1;
      slot[1].wrapped     = 1'b1;
    end else if (eos_in) begin
      vb = hv1 && big_enough(hc1, cfg.min_points);
      slot[1].point_count = COUNT_W'(hc1);
      slot[1].is_cluster  = 1'b1;
      vc = big_enough(oc1, cfg.min_points);
      slot[2].start_index = START_W'(os1);
      slot[2].point_count = COUNT_W'(oc1);
      slot[2].is_cluster  = 1'b1;
    end

    // bare end marker when the last sample yields no cluster record
    if (eos_in && !va && !vb && !vc) begin
      vc = 1'b1;
      slot[2] = '0;
    end

    slot[0].last_of_scan = eos_in && !vb && !vc;
    slot[1].last_of_scan = eos_in && !vc;
    slot[2].last_of_scan = eos_in;
    slot_valid = {vc, vb, va};

    idx_inc = (IDX_W + 1)'(sample_index) + (IDX_W + 1)'(1);

    if (eos_in) begin
      sample_index_next   = '0;
      previous_range_next = '0;
      first_range_next    = '0;
      open_start_next     = '0;
      open_count_next     = '0;
      held_count_next     = '0;
      held_valid_next     = 1'b0;
    end else begin
      sample_index_next   = (idx_inc >= IDX_LIM) ? IDX_TOP : idx_inc[IDX_W-1:0];
      previous_range_next = range_in;
      first_range_next    = first_eff;
      open_start_next     = os1;
      open_count_next     = oc1;
      held_count_next     = hc1;
      held_valid_next     = hv1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index   <= '0;
      previous_range <= '0;
      first_range    <= '0;
      open_start     <= '0;
      open_count     <= '0;
      held_count     <= '0;
      held_valid     <= 1'b0;
    end else if (fire) begin
      sample_index   <= sample_index_next;
      previous_range <= previous_range_next;
      first_range    <= first_range_next;
      open_start     <= open_start_next;
      open_count     <= open_count_next;
      held_count     <= held_count_next;
      held_valid     <= held_valid_next;
    end
  end

endmodule

>>> rtl/core/rsc_queue.sv
// ----------------------------------------------------------------------------
// rsc_queue
// Result queue: takes up to three records per cycle, packed in order,
// and hands them out one per transaction.
// ----------------------------------------------------------------------------
module rsc_queue import rsc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  res_t [SLOTS-1:0]  slot,
  input  logic [SLOTS-1:0]  slot_valid,
  output logic              room,
  output logic              head_valid,
  input  logic              head_taken,
  output res_t              head
);

  res_t               entry [Q_DEPTH];
  logic [Q_PTR_W-1:0] rd_ptr, wr_ptr;
  logic [Q_CNT_W-1:0] fill, fill_next;
  logic [Q_PTR_W-1:0] pos1, pos2;
  logic [1:0]         n_push;
  logic               pop;

  assign pos1   = wr_ptr + Q_PTR_W'(slot_valid[0]);
  assign pos2   = pos1 + Q_PTR_W'(slot_valid[1]);
  assign n_push = push ? (2'(slot_valid[0]) + 2'(slot_valid[1]) + 2'(slot_valid[2])) : 2'd0;
  assign pop    = head_valid && head_taken;

  assign head_valid = (fill != '0);
  assign head       = entry[rd_ptr];
  assign room       = (fill <= Q_CNT_W'(Q_DEPTH - SLOTS));
  assign fill_next  = fill + Q_CNT_W'(n_push) - Q_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push && slot_valid[0]) begin
      entry[wr_ptr] <= slot[0];
    end
    if (push && slot_valid[1]) begin
      entry[pos1] <= slot[1];
    end
    if (push && slot_valid[2]) begin
      entry[pos2] <= slot[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_PTR_W'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      fill <= fill_next;
    end
  end

endmodule

>>> test/range_scan_cluster_segmenter_tb.sv
// ----------------------------------------------------------------------------
// range_scan_cluster_segmenter_tb
// Drives range samples through the segmenter in whole scans and checks each
// result record against a cycle-free predictor of the segmentation, the
// wraparound merge and the end-of-scan marker. Runs several register
// settings and random flow control on both channels.
// ----------------------------------------------------------------------------
module range_scan_cluster_segmenter_tb import rsc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_POINTS = MAX_POINTS_DEF;
  localparam int N_DIR = 22;

  class cluster_scoreboard;
    logic [RANGE_W-1:0] jump_thr;
    logic [RANGE_W-1:0] min_valid;
    logic [RANGE_W-1:0] wrap_min;
    logic [MINP_W-1:0]  min_pts;

    logic [START_W-1:0] scan_idx;
    logic [RANGE_W-1:0] prev_r;
    logic [RANGE_W-1:0] first_r;
    logic [START_W-1:0] open_start;
    logic [COUNT_W-1:0] open_cnt;
    logic [COUNT_W-1:0] held_cnt;
    bit                 held_vld;

    res_t step_recs[$];
    res_t pending_records[$];
    int unsigned mismatches;

    function new();
      jump_thr = JUMP_THRESHOLD_RST;
      min_valid = MIN_VALID_RANGE_RST;
      wrap_min = WRAP_MIN_RANGE_RST;
      min_pts = MIN_POINTS_RST;
      mismatches = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      scan_idx = '0;
      prev_r = '0;
      first_r = '0;
      open_start = '0;
      open_cnt = '0;
      held_cnt = '0;
      held_vld = 1'b0;
    endfunction

    function void set_reg(logic [RIDX_W-1:0] idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_JUMP_THRESHOLD: jump_thr = val[RANGE_W-1:0];
        REG_MIN_VALID_RANGE: min_valid = val[RANGE_W-1:0];
        REG_WRAP_MIN_RANGE: wrap_min = val[RANGE_W-1:0];
        REG_MIN_POINTS: min_pts = val[MINP_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [RANGE_W-1:0] range_gap(logic [RANGE_W-1:0] a, logic [RANGE_W-1:0] b);
      return (a > b) ? a - b : b - a;
    endfunction

    function logic [COUNT_W-1:0] clip(int unsigned c);
      return (c > MAX_POINTS) ? COUNT_W'(MAX_POINTS) : COUNT_W'(c);
    endfunction

    // a zero minimum behaves as one: empty clusters never report
    function bit reportable(logic [COUNT_W-1:0] c);
      return c != 0 && c >= min_pts;
    endfunction

    function res_t make_rec(logic [START_W-1:0] start, logic [COUNT_W-1:0] count,
                            logic clus, logic wrap);
      res_t rec;
      rec.start_index = start;
      rec.point_count = count;
      rec.is_cluster = clus;
      rec.wrapped = wrap;
      rec.last_of_scan = 1'b0;
      return rec;
    endfunction

    function void add_rec(res_t rec);
      step_recs = {step_recs, rec};
    endfunction

    function void note_sample(logic [RANGE_W-1:0] r, logic eos);
      res_t last_rec;
      bit valid;
      step_recs.delete();
      valid = r > min_valid;
      if (scan_idx == 0) begin
        first_r = r;
        open_cnt = '0;
        held_cnt = '0;
        held_vld = 1'b0;
      end
      if (valid && open_cnt != 0 && range_gap(r, prev_r) < jump_thr) begin
        open_cnt = clip(open_cnt + 1);
      end else begin
        if (open_cnt != 0) begin
          // the cluster at sample 0 waits for a possible merge across the wrap
          if (open_start == 0) begin
            held_vld = 1'b1;
            held_cnt = open_cnt;
          end else if (reportable(open_cnt)) begin
            add_rec(make_rec(open_start, open_cnt, 1'b1, 1'b0));
          end
          open_cnt = '0;
        end
        if (valid) begin
          open_start = scan_idx;
          open_cnt = COUNT_W'(1);
        end
      end
      prev_r = r;
      if (eos) begin
        if (held_vld && open_cnt != 0 && range_gap(r, first_r) < jump_thr && r > wrap_min) begin
          if (reportable(clip(int'(open_cnt) + int'(held_cnt))))
            add_rec(make_rec(open_start, clip(int'(open_cnt) + int'(held_cnt)),
                             1'b1, 1'b1));
        end else begin
          if (held_vld && reportable(held_cnt))
            add_rec(make_rec('0, held_cnt, 1'b1, 1'b0));
          if (reportable(open_cnt))
            add_rec(make_rec(open_start, open_cnt, 1'b1, 1'b0));
        end
        if (step_recs.size() == 0)
          add_rec(make_rec('0, '0, 1'b0, 1'b0));
        last_rec = step_recs.pop_back();
        last_rec.last_of_scan = 1'b1;
        add_rec(last_rec);
        clear_scan();
      end else begin
        scan_idx = (scan_idx == MAX_POINTS - 1) ? scan_idx : scan_idx + 1'b1;
      end
      pending_records = {pending_records, step_recs};
    endfunction

    function void check_record(res_t got);
      res_t exp;
      if (pending_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected record: start=%0d count=%0d cluster=%0b wrap=%0b last=%0b",
                   got.start_index, got.point_count, got.is_cluster, got.wrapped,
                   got.last_of_scan);
      end else begin
        exp = pending_records.pop_front();
        if (got.start_index !== exp.start_index || got.point_count !== exp.point_count ||
            got.is_cluster !== exp.is_cluster || got.wrapped !== exp.wrapped ||
            got.last_of_scan !== exp.last_of_scan) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"record mismatch: expected start=%0d count=%0d cluster=%0b wrap=%0b",
                      " last=%0b, got start=%0d count=%0d cluster=%0b wrap=%0b last=%0b"},
                     exp.start_index, exp.point_count, exp.is_cluster, exp.wrapped,
                     exp.last_of_scan, got.start_index, got.point_count, got.is_cluster,
                     got.wrapped, got.last_of_scan);
        end
      end
    endfunction

    function int pending();
      return pending_records.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [RANGE_W-1:0] range_mm = '0;
  logic               end_of_scan = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [START_W-1:0] start_index;
  logic [COUNT_W-1:0] point_count;
  logic               is_cluster;
  logic               wrapped;
  logic               last_of_scan;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  bit idle_en = 1'b1;
  bit stall_en = 1'b1;
  cluster_scoreboard sb = new();

  logic [RANGE_W-1:0] dir_r [N_DIR] = '{1000, 1010, 1020, 40, 2000, 2010, 2020, 2030, 2040,
                                        3000, 1030, 1020, 0, 65535, 65535, 65535, 65535,
                                        120, 130, 30, 95, 90};
  logic dir_e [N_DIR] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 1,
                          0, 0, 0, 0, 1};

  range_scan_cluster_segmenter i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .range_mm(range_mm), .end_of_scan(end_of_scan),
    .out_valid(out_valid), .out_ready(out_ready),
    .start_index(start_index), .point_count(point_count), .is_cluster(is_cluster),
    .wrapped(wrapped), .last_of_scan(last_of_scan),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_record({start_index, point_count, is_cluster, wrapped, last_of_scan});
  end

  initial begin
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if (stall_en) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  task automatic send_sample(input logic [RANGE_W-1:0] r, input logic eos);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    range_mm <= r;
    end_of_scan <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(r, eos);
  endtask

  // hold the sender until every record is out, then let the pipeline settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [RIDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic set_config(input int unsigned jt, input int unsigned mv,
                            input int unsigned wm, input int unsigned mp);
    drain_results();
    write_reg(REG_JUMP_THRESHOLD, DATA_W'(jt));
    write_reg(REG_MIN_VALID_RANGE, DATA_W'(mv));
    write_reg(REG_WRAP_MIN_RANGE, DATA_W'(wm));
    write_reg(REG_MIN_POINTS, DATA_W'(mp));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [RANGE_W-1:0] near_range(logic [RANGE_W-1:0] base);
    int span;
    int v;
    span = (sb.jump_thr > 1) ? int'(sb.jump_thr) - 1 : 0;
    v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return RANGE_W'(v);
  endfunction

  function automatic logic [RANGE_W-1:0] walk_range(logic [RANGE_W-1:0] prev);
    case ($urandom_range(0, 11))
      0: return RANGE_W'($urandom_range(0, sb.min_valid));
      1: return RANGE_W'($urandom_range(0, 65535));
      2: return prev + sb.jump_thr;  // gap exactly at the threshold
      default: return near_range(prev);
    endcase
  endfunction

  task automatic send_scan(input int len, input bit noise);
    logic [RANGE_W-1:0] first_sample;
    logic [RANGE_W-1:0] r;
    first_sample = ($urandom_range(0, 4) == 0) ? RANGE_W'($urandom_range(0, 65535))
                                               : RANGE_W'($urandom_range(sb.min_valid, 65535));
    r = first_sample;
    for (int k = 0; k < len; k++) begin
      if (k > 0) r = noise ? RANGE_W'($urandom) : walk_range(r);
      // bend the tail back toward the first range to invite a wrap merge
      if (k == len - 1 && k > 0 && $urandom_range(0, 1) == 1) r = near_range(first_sample);
      send_sample(r, k == len - 1);
    end
  endtask

  task automatic run_scans(input int target, input int max_len);
    int sent;
    int len;
    sent = 0;
    while (sent < target) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, max_len);
      send_scan(len, $urandom_range(0, 7) == 0);
      sent += len;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < N_DIR; k++) send_sample(dir_r[k], dir_e[k]);

    set_config(65535, 0, 0, 1);
    run_scans(20, 24);

    set_config(0, 0, 65535, 0);
    run_scans(12, 12);

    set_config($urandom_range(0, 65535), 65535, $urandom_range(0, 65535),
               $urandom_range(1, 1024));
    run_scans(6, 6);

    set_config($urandom_range(1, 300), $urandom_range(0, 200), $urandom_range(0, 500),
               $urandom_range(1, 8));
    run_scans(20, 24);
    drain_results();
    run_scans(20, 24);

    set_config($urandom_range(1, 300), $urandom_range(0, 200), $urandom_range(0, 500),
               $urandom_range(1, 8));
    idle_en = 1'b0;
    stall_en = 1'b0;
    run_scans(25, 24);

    drain_results();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
